### sv/pfa_pkg.sv
// pfa_pkg: shared constants and codes for the page frame allocator
// request and status codes, register indexes, default sizes
// no dependencies
`timescale 1ns / 1ps

package pfa_pkg;

    // default geometry
    localparam int FRAMES_DEF     = 262144;
    localparam int PAGE_SHIFT_DEF = 12;

    // fixed field widths of the stream words
    localparam int ADDR_W      = 32;
    localparam int REG_W       = 31;
    localparam int REQ_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int PAGE_ADDR_W = 30;
    localparam int COUNT_W     = 16;
    localparam int FREE_PAGES_W = 19;
    localparam int CFG_IDX_W   = 1;

    // upper address limit after reset
    localparam logic [REG_W-1:0] TOP_RESET = 31'h3b40_0000;

    // saturation bounds of a reference count
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7fff;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = -16'sh8000;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 3'd0,
        REQ_FREE  = 3'd1,
        REQ_INC   = 3'd2,
        REQ_DEC   = 3'd3,
        REQ_READ  = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_BAD   = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWEST_FREE = 1'b0,
        CFG_TOP         = 1'b1
    } cfg_idx_t;

endpackage

### sv/pfa_ram.sv
// pfa_ram: generic single write port, single read port synchronous ram
// read data registered, no reset on contents
// no dependencies
`timescale 1ns / 1ps

module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/page_frame_allocator_refcount_core.sv
// page_frame_allocator_refcount_core: lifo free list page allocator with
// per-frame reference counts; state held in two pfa_ram instances
// depends on pfa_pkg and pfa_ram
`timescale 1ns / 1ps

// channel   | dir | handshake         | payload
// ----------+-----+-------------------+-----------------------------------------
// request   | in  | s_tvalid/s_tready | s_tuser req_type, s_tdata phys_addr
// result    | out | m_tvalid/m_tready | m_tuser status, m_tdata page/count/free
// config    | in  | cfg_we            | cfg_addr index, cfg_wdata value
//
// a request is accepted in S_IDLE, where the accept edge issues the reads of
// the stack and count rams; in S_EXEC, once the output register is free, the
// changed entries go back to the rams and the result register is loaded
// after reset the count ram is swept to zero, one entry a cycle,
// with s_tready low; config writes are taken during the sweep
// a result waiting in the output register does not block the accept of the
// next request; its write-back waits until the output register frees up

module page_frame_allocator_refcount_core #(
    parameter int FRAMES     = pfa_pkg::FRAMES_DEF,
    parameter int PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pfa_pkg::ADDR_W-1:0]     s_tdata,   // [31:0] phys_addr
    input  logic [pfa_pkg::REQ_W-1:0]      s_tuser,   // [2:0] req_type
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [71:0]                    m_tdata,   // [29:0] page_addr,
                                                      // [45:30] ref_count,
                                                      // [64:46] free_pages,
                                                      // [71:65] zero
    output logic [pfa_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
    // configuration write port
    input  logic                           cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [pfa_pkg::REG_W-1:0]      cfg_wdata
);

    localparam int FRAME_W = $clog2(FRAMES);
    localparam int CNT_W   = $clog2(FRAMES + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    // control and payload registers
    state_t                                state_reg, state_next;
    logic [FRAME_W-1:0]                    clr_reg, clr_next;
    logic [CNT_W-1:0]                      free_count_reg, free_count_next;
    logic [pfa_pkg::REQ_W-1:0]             req_reg, req_next;
    logic [pfa_pkg::ADDR_W-1:0]            addr_reg, addr_next;
    logic [pfa_pkg::REG_W-1:0]             lowest_reg, lowest_next;
    logic [pfa_pkg::REG_W-1:0]             top_reg, top_next;
    logic                                  out_valid_reg, out_valid_next;
    logic [pfa_pkg::STATUS_W-1:0]          status_reg, status_next;
    logic [pfa_pkg::PAGE_ADDR_W-1:0]       page_addr_reg, page_addr_next;
    logic signed [pfa_pkg::COUNT_W-1:0]    ref_count_reg, ref_count_next;
    logic [pfa_pkg::FREE_PAGES_W-1:0]      free_pages_reg, free_pages_next;

    // ram ports
    logic                                  stack_we, stack_re;
    logic [FRAME_W-1:0]                    stack_waddr, stack_raddr;
    logic [FRAME_W-1:0]                    stack_wdata, stack_rdata;
    logic                                  cnt_we, cnt_re;
    logic [FRAME_W-1:0]                    cnt_waddr, cnt_raddr;
    logic [pfa_pkg::COUNT_W-1:0]           cnt_wdata, cnt_rdata;

    // decode helpers
    logic                                  accept;
    logic                                  can_issue;
    logic [pfa_pkg::ADDR_W-1:0]            in_frame;
    logic [pfa_pkg::ADDR_W-1:0]            cur_frame;
    logic                                  frame_ok;
    logic                                  free_addr_bad;
    logic                                  stack_full;
    logic [63:0]                           page_wide;
    logic [31:0]                           free_wide;
    logic signed [pfa_pkg::COUNT_W-1:0]    cnt_old;
    logic signed [pfa_pkg::COUNT_W-1:0]    cnt_new;

    pfa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (FRAMES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (stack_re),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    pfa_ram #(
        .WIDTH (pfa_pkg::COUNT_W),
        .DEPTH (FRAMES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign can_issue = !out_valid_reg || m_tready;

    // frame number of the incoming word, used for the count read
    assign in_frame  = s_tdata >> PAGE_SHIFT;
    // frame number of the request in flight
    assign cur_frame = addr_reg >> PAGE_SHIFT;
    assign frame_ok  = (cur_frame < 32'(FRAMES));

    // free needs page alignment and lowest <= addr < top, and a real frame
    assign free_addr_bad = (addr_reg[PAGE_SHIFT-1:0] != '0)
                        || (addr_reg < {1'b0, lowest_reg})
                        || (addr_reg >= {1'b0, top_reg})
                        || !frame_ok;
    assign stack_full = (free_count_reg >= CNT_W'(FRAMES));

    assign cnt_old   = signed'(cnt_rdata);
    assign page_wide = 64'(stack_rdata) << PAGE_SHIFT;
    assign free_wide = 32'(free_count_next);

    // reads are issued on the accept edge: top of stack and the frame's count
    assign stack_re    = accept;
    assign stack_raddr = FRAME_W'(free_count_reg - CNT_W'(1));
    assign cnt_re      = accept;
    assign cnt_raddr   = in_frame[FRAME_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        free_count_next = free_count_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        lowest_next     = lowest_reg;
        top_next        = top_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        page_addr_next  = page_addr_reg;
        ref_count_next  = ref_count_reg;
        free_pages_next = free_pages_reg;

        stack_we    = 1'b0;
        stack_waddr = free_count_reg[FRAME_W-1:0];
        stack_wdata = cur_frame[FRAME_W-1:0];
        cnt_we      = 1'b0;
        cnt_waddr   = cur_frame[FRAME_W-1:0];
        cnt_wdata   = '0;
        cnt_new     = cnt_old;

        // result leaves when taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // configuration, taken in any state
        if (cfg_we)
        begin
            unique case (cfg_addr)
                pfa_pkg::CFG_LOWEST_FREE: lowest_next = cfg_wdata;
                pfa_pkg::CFG_TOP:         top_next    = cfg_wdata;
                default:                  ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // zero sweep of the count ram after reset
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                if (clr_reg == FRAME_W'(FRAMES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + FRAME_W'(1);
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = s_tuser;
                    addr_next  = s_tdata;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (can_issue)
                begin
                    status_next    = pfa_pkg::STATUS_OK;
                    page_addr_next = '0;
                    ref_count_next = '0;

                    unique case (req_reg) inside
                        pfa_pkg::REQ_ALLOC:
                        begin
                            if (free_count_reg == '0)
                            begin
                                status_next = pfa_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                // pop: the top entry was read on accept
                                free_count_next = free_count_reg - CNT_W'(1);
                                cnt_we          = 1'b1;
                                cnt_waddr       = stack_rdata;
                                cnt_wdata       = pfa_pkg::COUNT_W'(1);
                                ref_count_next  = pfa_pkg::COUNT_W'(1);
                                page_addr_next  = page_wide[pfa_pkg::PAGE_ADDR_W-1:0];
                            end
                        end

                        pfa_pkg::REQ_FREE:
                        begin
                            if (free_addr_bad)
                            begin
                                status_next = pfa_pkg::STATUS_BAD;
                            end
                            else if (stack_full)
                            begin
                                status_next = pfa_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                // push the frame and drop its count to zero
                                stack_we        = 1'b1;
                                free_count_next = free_count_reg + CNT_W'(1);
                                cnt_we          = 1'b1;
                                cnt_wdata       = '0;
                            end
                        end

                        pfa_pkg::REQ_INC, pfa_pkg::REQ_DEC, pfa_pkg::REQ_READ:
                        begin
                            if (!frame_ok)
                            begin
                                status_next = pfa_pkg::STATUS_BAD;
                            end
                            else
                            begin
                                // saturating update of the count read on accept
                                if (req_reg == pfa_pkg::REQ_INC
                                    && cnt_old != pfa_pkg::COUNT_MAX)
                                begin
                                    cnt_new = cnt_old + 16'sd1;
                                end
                                else if (req_reg == pfa_pkg::REQ_DEC
                                         && cnt_old != pfa_pkg::COUNT_MIN)
                                begin
                                    cnt_new = cnt_old - 16'sd1;
                                end
                                cnt_we         = 1'b1;
                                cnt_wdata      = cnt_new;
                                ref_count_next = cnt_new;
                            end
                        end

                        default:
                        begin
                            // unknown request: no state change
                        end
                    endcase

                    free_pages_next = free_wide[pfa_pkg::FREE_PAGES_W-1:0];
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // state, control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            free_count_reg <= '0;
            lowest_reg     <= '0;
            top_reg        <= pfa_pkg::TOP_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            free_count_reg <= free_count_next;
            lowest_reg     <= lowest_next;
            top_reg        <= top_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        status_reg     <= status_next;
        page_addr_reg  <= page_addr_next;
        ref_count_reg  <= ref_count_next;
        free_pages_reg <= free_pages_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, free_pages_reg, ref_count_reg, page_addr_reg};

endmodule
